FILE: src/lzwd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and hash functions of the LZW encoder dictionary.
package lzwd_pkg;

   localparam int MAX_CODE_BITS = 12;
   localparam int TABLE_ENTRIES = 6151;
   localparam int CHAR_BITS     = 8;
   localparam int ROOT_W        = 9;
   localparam int BITS_W        = 4;
   localparam int CODE_W        = MAX_CODE_BITS;
   localparam int SIZE_W        = MAX_CODE_BITS + 1;
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int KEY_W         = ROOT_W + 1;
   localparam int HASH_W        = KEY_W + MAX_CODE_BITS - CHAR_BITS;
   localparam int MAX_ENTRIES   = 1 << MAX_CODE_BITS;

   typedef enum logic [1:0] {
      CMD_FIND = 2'd0,
      CMD_ADD  = 2'd1,
      CMD_INIT = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic                 valid;
      logic [CODE_W-1:0]    code;
      logic [CODE_W-1:0]    base;
      logic [CHAR_BITS-1:0] chr;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      cmd_type              cmd;
      logic [CODE_W-1:0]    prefix_code;
      logic [CHAR_BITS-1:0] char_value;
      logic [SLOT_W-1:0]    slot_in;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot_out;
      logic [CODE_W-1:0] code_out;
      logic [SIZE_W-1:0] dict_size;
      logic [BITS_W-1:0] code_bits;
      logic [BITS_W-1:0] starting_bits;
      logic              error;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      entry_type         data;
   } ram_wr_type;

   // The key never reaches twice the table size, so one conditional subtract reduces it.
   function automatic logic [SLOT_W-1:0] hash_slot(input logic [KEY_W-1:0] chr,
                                                   input logic [CODE_W-1:0] code);
      logic [HASH_W-1:0] v;
      v = (HASH_W'(chr) << (MAX_CODE_BITS - CHAR_BITS)) ^ HASH_W'(code);
      if (v >= HASH_W'(TABLE_ENTRIES)) begin
         v = v - HASH_W'(TABLE_ENTRIES);
      end
      return v[SLOT_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] first_step(input logic [SLOT_W-1:0] idx);
      logic [SLOT_W-1:0] s;
      if (idx == '0) begin
         s = SLOT_W'(1);
      end else begin
         s = SLOT_W'(TABLE_ENTRIES) - idx;
      end
      return s;
   endfunction

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx,
                                                   input logic [SLOT_W-1:0] step);
      logic [SLOT_W:0] v;
      if (idx >= step) begin
         v = {1'b0, idx} - {1'b0, step};
      end else begin
         v = {1'b0, idx} + (SLOT_W + 1)'(TABLE_ENTRIES) - {1'b0, step};
      end
      return v[SLOT_W-1:0];
   endfunction

endpackage

FILE: src/lzwd_req_if.sv
`timescale 1ns / 1ps
// Command channel of the LZW encoder dictionary.
interface lzwd_req_if;
   logic                                valid;
   logic                                ready;
   lzwd_pkg::cmd_type                   cmd;
   logic [lzwd_pkg::CODE_W-1:0]         prefix_code;
   logic [lzwd_pkg::CHAR_BITS-1:0]      char_value;
   logic [lzwd_pkg::SLOT_W-1:0]         slot_in;

   modport source (output valid, cmd, prefix_code, char_value, slot_in, input ready);
   modport sink (input valid, cmd, prefix_code, char_value, slot_in, output ready);
endinterface

FILE: src/lzwd_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the LZW encoder dictionary.
interface lzwd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [lzwd_pkg::SLOT_W-1:0]   slot_out;
   logic [lzwd_pkg::CODE_W-1:0]   code_out;
   logic [lzwd_pkg::SIZE_W-1:0]   dict_size;
   logic [lzwd_pkg::BITS_W-1:0]   code_bits;
   logic [lzwd_pkg::BITS_W-1:0]   starting_bits;
   logic                          error;

   modport source (output valid, found, slot_out, code_out, dict_size, code_bits,
                   starting_bits, error, input ready);
   modport sink (input valid, found, slot_out, code_out, dict_size, code_bits,
                 starting_bits, error, output ready);
endinterface

FILE: src/lzwd_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
module lzwd_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: src/lzwd_engine.sv
`timescale 1ns / 1ps
// Command sequencer: probes, inserts into and clears the slot table.
module lzwd_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [lzwd_pkg::ROOT_W-1:0]    root_codes,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lzwd_pkg::req_type              req,
   output logic                           res_valid,
   input  logic                           res_ready,
   output lzwd_pkg::rsp_type              res,
   output lzwd_pkg::ram_wr_type           ram_wr,
   output logic [lzwd_pkg::SLOT_W-1:0]    ram_rd_addr,
   input  lzwd_pkg::entry_type            ram_rd_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   state_type                        state_ff;
   lzwd_pkg::cmd_type                cmd_ff;
   logic [lzwd_pkg::SLOT_W-1:0]      addr_ff;
   logic [lzwd_pkg::SLOT_W-1:0]      step_ff;
   logic [lzwd_pkg::SLOT_W-1:0]      probes_ff;
   logic [lzwd_pkg::SLOT_W-1:0]      slot_ff;
   logic                             err_ff;
   logic [lzwd_pkg::CODE_W-1:0]      key_code_ff;
   logic [lzwd_pkg::KEY_W-1:0]       key_chr_ff;
   logic [lzwd_pkg::SIZE_W-1:0]      count_ff;
   logic [lzwd_pkg::BITS_W-1:0]      width_ff;
   logic [lzwd_pkg::BITS_W-1:0]      width_init_ff;

   logic                             empty;
   logic                             hit;
   logic                             last_probe;
   logic                             stop;
   logic                             can_insert;
   logic                             grow;
   logic [lzwd_pkg::BITS_W-1:0]      width_next;
   logic [lzwd_pkg::SLOT_W-1:0]      probe_next;
   logic [lzwd_pkg::SLOT_W-1:0]      find_hash;
   logic [lzwd_pkg::KEY_W-1:0]       key_next;
   logic [lzwd_pkg::KEY_W-1:0]       init_total;
   logic [lzwd_pkg::SLOT_W-1:0]      init_hash;
   logic                             init_insert;
   logic                             init_last;
   logic [31:0]                      count_wide;

   always_comb begin
      empty      = !ram_rd_data.valid;
      hit        = ram_rd_data.valid && (ram_rd_data.base != ram_rd_data.code) &&
                   (ram_rd_data.base == key_code_ff) &&
                   (lzwd_pkg::KEY_W'(ram_rd_data.chr) == key_chr_ff);
      last_probe = probes_ff == lzwd_pkg::SLOT_W'(lzwd_pkg::TABLE_ENTRIES - 1);
      stop       = empty || hit || last_probe;
      can_insert = count_ff < lzwd_pkg::SIZE_W'(lzwd_pkg::MAX_ENTRIES);
      count_wide = 32'(count_ff);
      grow       = count_wide == (32'd1 << width_ff);
      width_next = grow ? width_ff + lzwd_pkg::BITS_W'(1) : width_ff;
      probe_next = lzwd_pkg::next_slot(addr_ff, step_ff);
      find_hash  = lzwd_pkg::hash_slot(lzwd_pkg::KEY_W'(req.char_value), req.prefix_code);
      key_next   = (state_ff == ST_CLEAR) ? '0 : key_chr_ff + lzwd_pkg::KEY_W'(1);
      init_total = lzwd_pkg::KEY_W'(root_codes) + lzwd_pkg::KEY_W'(2);
      init_hash  = lzwd_pkg::hash_slot(key_next, lzwd_pkg::CODE_W'(key_next));
      init_insert = empty && can_insert;
      init_last  = key_next == init_total;
   end

   assign req_ready   = state_ff == ST_IDLE;
   assign ram_rd_addr = addr_ff;

   always_comb begin
      ram_wr.en   = 1'b0;
      ram_wr.addr = addr_ff;
      ram_wr.data = '0;
      if (state_ff == ST_CLEAR) begin
         ram_wr.en = 1'b1;
      end else if (state_ff == ST_CHECK) begin
         ram_wr.data.valid = 1'b1;
         ram_wr.data.code  = count_ff[lzwd_pkg::CODE_W-1:0];
         ram_wr.data.base  = key_code_ff;
         ram_wr.data.chr   = key_chr_ff[lzwd_pkg::CHAR_BITS-1:0];
         if (cmd_ff == lzwd_pkg::CMD_ADD) begin
            ram_wr.en = empty && res_ready;
         end else if (cmd_ff == lzwd_pkg::CMD_INIT) begin
            ram_wr.en = init_insert;
         end
      end
   end

   always_comb begin
      res               = '0;
      res.dict_size     = count_ff;
      res.code_bits     = width_ff;
      res.starting_bits = width_init_ff;
      res_valid         = 1'b0;
      if (state_ff == ST_DONE) begin
         res_valid    = 1'b1;
         res.slot_out = slot_ff;
         res.error    = err_ff;
      end else if (state_ff == ST_CHECK && cmd_ff == lzwd_pkg::CMD_FIND) begin
         res_valid    = stop;
         res.found    = hit;
         res.slot_out = (empty || hit) ? addr_ff : '0;
         res.code_out = hit ? ram_rd_data.code : '0;
         res.error    = !empty && !hit;
      end else if (state_ff == ST_CHECK && cmd_ff == lzwd_pkg::CMD_ADD) begin
         res_valid    = 1'b1;
         res.slot_out = addr_ff;
         if (empty) begin
            res.code_out  = count_ff[lzwd_pkg::CODE_W-1:0];
            res.dict_size = count_ff + lzwd_pkg::SIZE_W'(1);
            res.code_bits = width_next;
         end else begin
            res.error = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cmd_ff        <= lzwd_pkg::CMD_NOP;
         addr_ff       <= '0;
         step_ff       <= '0;
         probes_ff     <= '0;
         slot_ff       <= '0;
         err_ff        <= 1'b0;
         key_code_ff   <= '0;
         key_chr_ff    <= '0;
         count_ff      <= '0;
         width_ff      <= '0;
         width_init_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (addr_ff == lzwd_pkg::SLOT_W'(lzwd_pkg::TABLE_ENTRIES - 1)) begin
                  if (cmd_ff == lzwd_pkg::CMD_INIT) begin
                     key_chr_ff  <= key_next;
                     key_code_ff <= lzwd_pkg::CODE_W'(key_next);
                     addr_ff     <= init_hash;
                     step_ff     <= lzwd_pkg::first_step(init_hash);
                     probes_ff   <= '0;
                     state_ff    <= ST_READ;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  addr_ff <= addr_ff + lzwd_pkg::SLOT_W'(1);
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff <= req.cmd;
                  unique case (req.cmd)
                     lzwd_pkg::CMD_FIND: begin
                        key_code_ff <= req.prefix_code;
                        key_chr_ff  <= lzwd_pkg::KEY_W'(req.char_value);
                        addr_ff     <= find_hash;
                        step_ff     <= lzwd_pkg::first_step(find_hash);
                        probes_ff   <= '0;
                        state_ff    <= ST_READ;
                     end
                     lzwd_pkg::CMD_ADD: begin
                        key_code_ff <= req.prefix_code;
                        key_chr_ff  <= lzwd_pkg::KEY_W'(req.char_value);
                        addr_ff     <= req.slot_in;
                        slot_ff     <= req.slot_in;
                        if (!can_insert ||
                            req.slot_in >= lzwd_pkg::SLOT_W'(lzwd_pkg::TABLE_ENTRIES)) begin
                           err_ff   <= 1'b1;
                           state_ff <= ST_DONE;
                        end else begin
                           state_ff <= ST_READ;
                        end
                     end
                     lzwd_pkg::CMD_INIT: begin
                        count_ff <= '0;
                        width_ff <= '0;
                        addr_ff  <= '0;
                        slot_ff  <= '0;
                        err_ff   <= 1'b0;
                        state_ff <= ST_CLEAR;
                     end
                     lzwd_pkg::CMD_NOP: begin
                        slot_ff  <= '0;
                        err_ff   <= 1'b0;
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_READ: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               unique case (cmd_ff)
                  lzwd_pkg::CMD_FIND: begin
                     if (stop) begin
                        if (res_ready) begin
                           state_ff <= ST_IDLE;
                        end
                     end else begin
                        addr_ff   <= probe_next;
                        probes_ff <= probes_ff + lzwd_pkg::SLOT_W'(1);
                        state_ff  <= ST_READ;
                     end
                  end
                  lzwd_pkg::CMD_ADD: begin
                     if (res_ready) begin
                        if (empty) begin
                           count_ff <= count_ff + lzwd_pkg::SIZE_W'(1);
                           width_ff <= width_next;
                        end
                        state_ff <= ST_IDLE;
                     end
                  end
                  lzwd_pkg::CMD_INIT: begin
                     if (stop) begin
                        if (init_insert) begin
                           count_ff <= count_ff + lzwd_pkg::SIZE_W'(1);
                           width_ff <= width_next;
                        end
                        if (init_last) begin
                           width_init_ff <= init_insert ? width_next : width_ff;
                           state_ff      <= ST_DONE;
                        end else begin
                           key_chr_ff  <= key_next;
                           key_code_ff <= lzwd_pkg::CODE_W'(key_next);
                           addr_ff     <= init_hash;
                           step_ff     <= lzwd_pkg::first_step(init_hash);
                           probes_ff   <= '0;
                           state_ff    <= ST_READ;
                        end
                     end else begin
                        addr_ff   <= probe_next;
                        probes_ff <= probes_ff + lzwd_pkg::SLOT_W'(1);
                        state_ff  <= ST_READ;
                     end
                  end
                  lzwd_pkg::CMD_NOP: begin
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            ST_DONE: begin
               if (res_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: src/lzw_encode_dictionary.sv
`timescale 1ns / 1ps
// Top level of the LZW encoder dictionary: hash table of 6151 slots in one synchronous RAM.
// One command beat is taken at a time and answered by exactly one result beat. A find makes
// one read of the single RAM read port for every probe, until a probed slot ends the search.
// An add ends early with an error when the dictionary is full or the slot lies beyond the
// table. An init clears the table in one write per slot and then places root_codes + 2
// entries, each with one RAM read per probe. After reset the same clearing pass runs before
// the first command beat is accepted; register writes are taken at any time. The result sits
// in an output register, so the next command can be accepted while a result beat still waits
// to be taken.
module lzw_encode_dictionary (
   input  logic                        clock,
   input  logic                        reset,
   lzwd_req_if.sink                    req_chan,
   lzwd_rsp_if.source                  rsp_chan,
   input  logic                        csr_we,
   input  logic [lzwd_pkg::ROOT_W-1:0] csr_wdata
);

   logic [lzwd_pkg::ROOT_W-1:0]  root_codes_ff;
   logic                         rsp_valid_ff;
   lzwd_pkg::rsp_type            rsp_ff;

   lzwd_pkg::req_type            req;
   lzwd_pkg::rsp_type            res;
   logic                         res_valid;
   logic                         res_ready;
   lzwd_pkg::ram_wr_type         ram_wr;
   logic [lzwd_pkg::SLOT_W-1:0]  ram_rd_addr;
   logic [lzwd_pkg::ENTRY_W-1:0] ram_rd_raw;

   always_comb begin
      req.cmd         = req_chan.cmd;
      req.prefix_code = req_chan.prefix_code;
      req.char_value  = req_chan.char_value;
      req.slot_in     = req_chan.slot_in;
   end

   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_codes_ff <= lzwd_pkg::ROOT_W'(256);
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            root_codes_ff <= csr_wdata;
         end
         if (res_valid && res_ready) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.found         = rsp_ff.found;
   assign rsp_chan.slot_out      = rsp_ff.slot_out;
   assign rsp_chan.code_out      = rsp_ff.code_out;
   assign rsp_chan.dict_size     = rsp_ff.dict_size;
   assign rsp_chan.code_bits     = rsp_ff.code_bits;
   assign rsp_chan.starting_bits = rsp_ff.starting_bits;
   assign rsp_chan.error         = rsp_ff.error;

   lzwd_ram #(
      .DEPTH (lzwd_pkg::TABLE_ENTRIES),
      .WIDTH (lzwd_pkg::ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   lzwd_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .root_codes  (root_codes_ff),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req         (req),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .ram_wr      (ram_wr),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (lzwd_pkg::entry_type'(ram_rd_raw))
   );

endmodule
